@@ rtl/nsqrt_pkg.sv @@
// Package for the Newton square root block: widths, defaults, controller states,
// word types and the powers of ten behind the tolerance table. No dependencies.
package nsqrt_pkg;
  localparam int ValueW     = 64;
  localparam int RootW      = 48;
  localparam int IterW      = 10;
  localparam int DigitsW    = 4;
  localparam int IterLimitD = 1000;
  localparam int FracBitsD  = 32;
  localparam logic [DigitsW-1:0] DigitsReset = 4'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_DIV, S_UPD, S_OUT
  } nsqrt_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic div_start;
    logic update;
  } nsqrt_cmd_t;

  typedef struct packed {
    logic special;
    logic div_busy;
    logic div_done;
    logic converged;
  } nsqrt_sts_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
  } nsqrt_in_t;

  typedef struct packed {
    logic [RootW-1:0] root;
    logic [IterW-1:0] iterations;
    logic             invalid;
    logic             limit_hit;
  } nsqrt_out_t;

  // Ten to the power n, used only to build constant tables.
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < n; k++) p = p * 64'd10;
    return p;
  endfunction
endpackage

@@ rtl/nsqrt_if.sv @@
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; the payload type is a parameter.
interface nsqrt_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/nsqrt_div.sv @@
// Restoring divider, one quotient bit per cycle: floor((a << FRAC) / d), saturating.
// Depends on nsqrt_pkg.
module nsqrt_div import nsqrt_pkg::*; #(
  parameter int FRAC_BITS = FracBitsD
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] d,
  output logic        busy,
  output logic        done,
  output logic [63:0] q
);
  logic [63:0] rem_r, rem_nxt, lo_r, q_r, q_nxt;
  logic [63:0] d_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [63:0] hi, shifted;
  logic        carry;

  assign hi = a >> (64 - FRAC_BITS);
  assign carry = rem_r[63];
  assign shifted = {rem_r[62:0], lo_r[63]};

  always_comb begin
    rem_nxt = shifted;
    q_nxt = {q_r[62:0], 1'b0};
    if (carry || shifted >= d_r) begin
      rem_nxt = shifted - d_r;
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (hi >= d) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= 7'd64;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= hi;
      lo_r  <= a << FRAC_BITS;
      d_r   <= d;
      q_r   <= (hi >= d) ? '1 : '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[62:0], 1'b0};
      q_r   <= q_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign q = q_r;
endmodule

@@ rtl/nsqrt_dp.sv @@
// Datapath: operand, estimate, step counter, tolerance and shared divider.
// Depends on nsqrt_pkg and nsqrt_div.
module nsqrt_dp import nsqrt_pkg::*; #(
  parameter int ITER_LIMIT = IterLimitD,
  parameter int FRAC_BITS  = FracBitsD
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nsqrt_cmd_t         cmd,
  output nsqrt_sts_t         sts,
  input  logic [63:0]        value,
  input  logic               cfg_we,
  input  logic [DigitsW-1:0] cfg_wdata,
  output logic [RootW-1:0]   root,
  output logic [IterW-1:0]   iterations,
  output logic               invalid,
  output logic               limit_hit
);
  localparam logic [63:0] One = 64'd1 << FRAC_BITS;
  logic [DigitsW-1:0] digits_r;
  logic [63:0] a_r, x0_r, x1_r, tol_r, q, x1c, err, x0g;
  logic [63:0] tol_tab [2**DigitsW];
  logic [IterW-1:0] steps_r;
  logic inv_r, lim_r, div_busy, div_done;

  // Rounded 10^-digits in fixed point, never below one LSB.
  for (genvar k = 0; k < 2**DigitsW; k++) begin : g_tol
    localparam logic [63:0] Pow = pow10(k);
    localparam logic [63:0] Raw = ((64'd1 << FRAC_BITS) + (Pow >> 1)) / Pow;
    assign tol_tab[k] = (Raw == 64'd0) ? 64'd1 : Raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) digits_r <= DigitsReset;
    else if (cfg_we) digits_r <= cfg_wdata;
  end

  assign sts.special = a_r[63] || a_r == 64'd0 || a_r == One;
  assign x0g = (a_r > One) ? (a_r + One) >> 1 : a_r >> 1;
  assign x1c = (x0_r >> 1) + (q >> 1) + {63'd0, x0_r[0] & q[0]};
  assign err = (x0_r > x1_r) ? x0_r - x1_r : x1_r - x0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      lim_r   <= 1'b0;
      inv_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        a_r     <= value;
        tol_r   <= tol_tab[digits_r];
        steps_r <= '0;
        lim_r   <= 1'b0;
        inv_r   <= value[63];
        x1_r    <= value[63] ? 64'd0 : value;
      end
      if (cmd.init) x0_r <= (x0g == 64'd0) ? 64'd1 : x0g;
      if (div_done) begin
        x1_r    <= x1c;
        steps_r <= steps_r + IterW'(1);
      end
      if (cmd.update) begin
        x0_r <= (x1_r == 64'd0) ? 64'd1 : x1_r;
        if (err > tol_r && 32'(steps_r) >= ITER_LIMIT) lim_r <= 1'b1;
      end
    end
  end

  assign sts.converged = (err <= tol_r) || 32'(steps_r) >= ITER_LIMIT;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;

  nsqrt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .a(a_r), .d(x0_r),
    .busy(div_busy), .done(div_done), .q(q)
  );

  assign root = x1_r[RootW-1:0];
  assign iterations = steps_r;
  assign invalid = inv_r;
  assign limit_hit = lim_r;

`ifndef SYNTHESIS
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    inv_r && !cmd.load |-> x1_r == 64'd0) else $error("invalid without zero root");
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    32'(steps_r) <= ITER_LIMIT || inv_r) else $error("step count past limit");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy) else $error("divider restarted while busy");
`endif
endmodule

@@ rtl/nsqrt_ctrl.sv @@
// Controller state machine sequencing load, Newton steps and result hand-off.
// Depends on nsqrt_pkg.
module nsqrt_ctrl import nsqrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output nsqrt_cmd_t cmd,
  input  nsqrt_sts_t sts
);
  nsqrt_state_t state_r, state_nxt;
  // Marks that the divide for the current step has been launched.
  logic dstarted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_INIT;
      S_INIT: state_nxt = sts.special ? S_OUT : S_DIV;
      S_DIV:  if (sts.div_done) state_nxt = S_UPD;
      S_UPD:  state_nxt = sts.converged ? S_OUT : S_DIV;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_INIT: begin
        cmd.init = !sts.special;
        cmd.div_start = 1'b0;
      end
      S_DIV: cmd.div_start = !sts.div_busy && !sts.div_done && !dstarted_r;
      S_UPD: cmd.update = 1'b1;
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dstarted_r <= 1'b0;
    else if (state_r != S_DIV || sts.div_done) dstarted_r <= 1'b0;
    else if (cmd.div_start) dstarted_r <= 1'b1;
  end

`ifndef SYNTHESIS
  a_hs: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV) else $error("divide finished outside step");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule

@@ rtl/newton_square_root.sv @@
// Top level of the Newton-Raphson square root block.
// Depends on nsqrt_pkg, nsqrt_if, nsqrt_ctrl and nsqrt_dp.
//
// Usage: one word on in_ch (signed Q32.32 value) yields one word on out_ch
// (root in Q16.32, step count, invalid and limit flags). cfg_we/cfg_wdata set
// the number of tolerance digits (reset 6); write only while idle.
// Negative, zero or one operands skip the Newton steps and go from the init
// state straight to the result. Otherwise each Newton step runs the shared
// bit-serial divider, which produces one quotient bit per cycle, and an item
// takes at most ITER_LIMIT steps.
// One item is in flight at a time; the next word is taken after the result
// is taken. A stalled receiver holds the result steady on out_ch.
// Synchronous active-low reset returns to idle and restores the digits.
module newton_square_root import nsqrt_pkg::*; #(
  parameter int ITER_LIMIT = IterLimitD,
  parameter int FRAC_BITS  = FracBitsD
) (
  input  logic               clk,
  input  logic               rst_n,
  nsqrt_if.sink              in_ch,
  nsqrt_if.source            out_ch,
  input  logic               cfg_we,
  input  logic [DigitsW-1:0] cfg_wdata
);
  nsqrt_cmd_t cmd;
  nsqrt_sts_t sts;
  logic [RootW-1:0] root;
  logic [IterW-1:0] iterations;
  logic invalid, limit_hit;

  nsqrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .sts(sts)
  );

  nsqrt_dp #(.ITER_LIMIT(ITER_LIMIT), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .value(in_ch.data.value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .root(root), .iterations(iterations),
    .invalid(invalid), .limit_hit(limit_hit)
  );

  assign out_ch.data.root = root;
  assign out_ch.data.iterations = iterations;
  assign out_ch.data.invalid = invalid;
  assign out_ch.data.limit_hit = limit_hit;
endmodule
